// ===== rtl/hmac_sha256_stream_macros.svh =====
// assertion macros used by the checker file
`ifndef HMAC_SHA256_STREAM_MACROS_SVH
`define HMAC_SHA256_STREAM_MACROS_SVH

// same-cycle implication
`define HSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define HSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/hss_pkg.sv =====
// shared types, constants and sha-256 helper functions
`default_nettype none
package hss_pkg;

	localparam int KeyWords = 8;
	localparam logic [7:0] IpadByte = 8'h36;
	localparam logic [7:0] OpadByte = 8'h5c;
	localparam int QueueDepth = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       no_data;
	} item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic        last_word;
	} result_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hmac_sha256_stream.sv =====
// hmac-sha-256 over a byte stream: key registers, input queue and hashing back end
// a byte that completes a 64-byte block adds a compression (64 rounds of one shared
// round unit plus load, chain update and return); the first word of a message adds
// the inner key block; a final word adds 3 blocks, or 4 when the length spills into
// a fourth block, before 4 digest words; reset clears queues, sequencer and length,
// loads the iv as chain value, and key registers reset to zero
`default_nettype none
module hmac_sha256_stream (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic        no_data,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      digest_word,
	output logic             last_word
);

	logic [63:0]    key_q [hss_pkg::KeyWords];
	logic           item_valid;
	logic           item_pop;
	hss_pkg::item_t item;

	assign pready = 1'b1;
	assign prdata = key_q[paddr[5:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hss_pkg::KeyWords; i++) key_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			key_q[paddr[5:3]] <= pwdata;
		end
	end

	hss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.no_data    (no_data),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	hss_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         (key_q),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.last_word   (last_word)
	);

endmodule
`default_nettype wire

// ===== rtl/hss_front.sv =====
// input side: accepts items, drops empty non-final ones, queues the rest
`default_nettype none
module hss_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic [7:0]    data_byte,
	input  wire logic          last_byte,
	input  wire logic          no_data,
	output logic               item_valid,
	output hss_pkg::item_t     item,
	input  wire logic          item_pop
);

	hss_pkg::item_t mem_q [hss_pkg::QueueDepth];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       keep;
	logic       wr;
	logic       rd;

	assign full = (cnt_q == 3'(hss_pkg::QueueDepth));
	assign keep = !(no_data && !last_byte);
	assign wr = push && !full && keep;
	assign rd = item_pop && (cnt_q != 3'd0);
	assign item_valid = (cnt_q != 3'd0);
	assign item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= '{data_byte: data_byte, last_byte: last_byte, no_data: no_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			if (wr && !rd) cnt_q <= cnt_q + 3'd1;
			else if (rd && !wr) cnt_q <= cnt_q - 3'd1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hss_back.sv =====
// hashing side: block buffer, padding sequencer, sha-256 round unit, result queue
`default_nettype none
module hss_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [63:0]   key [hss_pkg::KeyWords],
	input  wire logic          item_valid,
	input  wire hss_pkg::item_t item,
	output logic               item_pop,
	output logic               empty,
	input  wire logic          pop,
	output logic [63:0]        digest_word,
	output logic               last_word
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_BYTE  = 13'b0000000000010,
		S_CHK   = 13'b0000000000100,
		S_TAIL  = 13'b0000000001000,
		S_PAD1  = 13'b0000000010000,
		S_PAD2  = 13'b0000000100000,
		S_PAD3  = 13'b0000001000000,
		S_INNER = 13'b0000010000000,
		S_OUTER = 13'b0000100000000,
		S_EMIT  = 13'b0001000000000,
		S_CINIT = 13'b0010000000000,
		S_ROUND = 13'b0100000000000,
		S_CFIN  = 13'b1000000000000
	} state_t;

	state_t         state_q;
	state_t         ret_q;
	hss_pkg::item_t item_q;
	hss_pkg::item_t cur;
	logic [63:0]    len_q;
	logic [63:0]    bits;
	logic [31:0]    chain_q [8];
	logic [31:0]    buf_q [16];
	logic [31:0]    sched_q [16];
	logic [31:0]    vars_q [8];
	logic [5:0]     rnd_q;
	logic           extra_q;
	logic [1:0]     emit_q;
	logic [5:0]     bidx;
	logic           start_msg;
	logic           byte_go;
	logic           blk_full;
	logic           tail_go;
	logic           emit_go;
	logic [31:0]    t1;
	logic [31:0]    t2;
	logic [31:0]    w_new;

	hss_pkg::result_t oq_q [hss_pkg::QueueDepth];
	logic [1:0]     owp_q;
	logic [1:0]     orp_q;
	logic [2:0]     ocnt_q;
	logic           opop;

	assign cur = (state_q == S_IDLE) ? item : item_q;
	assign bidx = len_q[5:0];
	assign bits = {len_q[60:0], 3'b000};
	assign start_msg = (state_q == S_IDLE) && item_valid && (len_q == 64'd0);
	assign byte_go = ((state_q == S_IDLE) && item_valid && (len_q != 64'd0)) ||
		(state_q == S_BYTE);
	assign blk_full = !item_q.no_data && (len_q[5:0] == 6'd0);
	assign tail_go = (state_q == S_TAIL) || ((state_q == S_CHK) && !blk_full);
	assign emit_go = (state_q == S_EMIT) && ((emit_q != 2'd0) || (ocnt_q == 3'd0));
	assign item_pop = (state_q == S_IDLE) && item_valid;

	// one sha-256 round and the next schedule word
	assign t1 = vars_q[7] + hss_pkg::big_s1(vars_q[4]) +
		((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6])) + hss_pkg::K[rnd_q] + sched_q[0];
	assign t2 = hss_pkg::big_s0(vars_q[0]) +
		((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
	assign w_new = hss_pkg::small_s1(sched_q[14]) + sched_q[9] +
		hss_pkg::small_s0(sched_q[1]) + sched_q[0];

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) item_q <= item;
		if (byte_go && !cur.no_data) begin
			buf_q[bidx[5:2]][{~bidx[1:0], 3'b000} +: 8] <= cur.data_byte;
		end
		if (tail_go && item_q.last_byte) begin
			for (int p = 0; p < 64; p++) begin
				if (6'(p) == bidx) buf_q[p >> 2][(3 - (p & 3)) * 8 +: 8] <= 8'h80;
				else if (6'(p) > bidx) buf_q[p >> 2][(3 - (p & 3)) * 8 +: 8] <= 8'h00;
			end
			extra_q <= (bidx[5:3] == 3'b111);
		end
		if (state_q == S_PAD2) begin
			if (extra_q) begin
				for (int i = 0; i < 14; i++) buf_q[i] <= '0;
			end
			buf_q[14] <= bits[63:32];
			buf_q[15] <= bits[31:0];
		end
		if (state_q == S_INNER) begin
			for (int i = 0; i < 8; i++) buf_q[i] <= chain_q[i];
			buf_q[8] <= 32'h80000000;
			for (int i = 9; i < 15; i++) buf_q[i] <= '0;
			buf_q[15] <= 32'd768;
		end
		// schedule loads: key block or buffered block
		if (start_msg || state_q == S_INNER) begin
			for (int i = 0; i < 16; i++) begin
				sched_q[i] <= ((i & 1) != 0 ? key[i >> 1][31:0] : key[i >> 1][63:32]) ^
					{4{start_msg ? hss_pkg::IpadByte : hss_pkg::OpadByte}};
			end
		end else if ((state_q == S_CHK && blk_full) || (state_q == S_PAD1 && extra_q) ||
			state_q == S_PAD3 || state_q == S_OUTER) begin
			for (int i = 0; i < 16; i++) sched_q[i] <= buf_q[i];
		end else if (state_q == S_ROUND) begin
			for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i + 1];
			sched_q[15] <= w_new;
		end
		if (state_q == S_CINIT) begin
			for (int i = 0; i < 8; i++) vars_q[i] <= chain_q[i];
		end else if (state_q == S_ROUND) begin
			vars_q[7] <= vars_q[6];
			vars_q[6] <= vars_q[5];
			vars_q[5] <= vars_q[4];
			vars_q[4] <= vars_q[3] + t1;
			vars_q[3] <= vars_q[2];
			vars_q[2] <= vars_q[1];
			vars_q[1] <= vars_q[0];
			vars_q[0] <= t1 + t2;
		end
		if (emit_go) begin
			oq_q[owp_q] <= '{digest_word: {chain_q[{emit_q, 1'b0}], chain_q[{emit_q, 1'b1}]},
				last_word: (emit_q == 2'd3)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			len_q <= '0;
			rnd_q <= '0;
			emit_q <= '0;
			chain_q <= hss_pkg::IV;
		end else begin
			if (byte_go && !cur.no_data) len_q <= len_q + 64'd1;
			unique case (state_q)
				S_IDLE: begin
					if (start_msg) begin
						chain_q <= hss_pkg::IV;
						len_q <= 64'd64;
						ret_q <= S_BYTE;
						state_q <= S_CINIT;
					end else if (item_valid) begin
						state_q <= S_CHK;
					end
				end
				S_BYTE: state_q <= S_CHK;
				S_CHK: begin
					if (blk_full) begin
						ret_q <= S_TAIL;
						state_q <= S_CINIT;
					end else begin
						state_q <= item_q.last_byte ? S_PAD1 : S_IDLE;
					end
				end
				S_TAIL: state_q <= item_q.last_byte ? S_PAD1 : S_IDLE;
				S_PAD1: begin
					if (extra_q) begin
						ret_q <= S_PAD2;
						state_q <= S_CINIT;
					end else begin
						state_q <= S_PAD2;
					end
				end
				S_PAD2: state_q <= S_PAD3;
				S_PAD3: begin
					ret_q <= S_INNER;
					state_q <= S_CINIT;
				end
				S_INNER: begin
					chain_q <= hss_pkg::IV;
					ret_q <= S_OUTER;
					state_q <= S_CINIT;
				end
				S_OUTER: begin
					ret_q <= S_EMIT;
					state_q <= S_CINIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						emit_q <= emit_q + 2'd1;
						if (emit_q == 2'd3) begin
							chain_q <= hss_pkg::IV;
							len_q <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_CINIT: begin
					rnd_q <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= S_CFIN;
				end
				S_CFIN: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + vars_q[i];
					state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result queue, filling starts only when empty so all four words fit
	assign empty = (ocnt_q == 3'd0);
	assign opop = pop && !empty;
	assign digest_word = oq_q[orp_q].digest_word;
	assign last_word = oq_q[orp_q].last_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= '0;
			orp_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (emit_go) owp_q <= owp_q + 2'd1;
			if (opop) orp_q <= orp_q + 2'd1;
			if (emit_go && !opop) ocnt_q <= ocnt_q + 3'd1;
			else if (opop && !emit_go) ocnt_q <= ocnt_q - 3'd1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hss_checker.sv =====
// port-level checks for the hmac stream block, bound to the top level
`default_nettype none
`include "hmac_sha256_stream_macros.svh"
module hss_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pready,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [63:0] digest_word,
	input wire logic        last_word
);

	`HSS_ASSERT_NEXT(a_word_held, clk, arst_n, !empty && !pop, !empty)
	`HSS_ASSERT_NEXT(a_word_stable, clk, arst_n, !empty && !pop, $stable(digest_word) && $stable(last_word))
	`HSS_ASSERT_NEXT(a_digest_burst, clk, arst_n, pop && !empty && !last_word, !empty)
	`HSS_ASSERT_NOW(a_pready_high, clk, arst_n, 1'b1, pready)

endmodule

bind hmac_sha256_stream hss_checker u_hss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pready      (pready),
	.empty       (empty),
	.pop         (pop),
	.digest_word (digest_word),
	.last_word   (last_word)
);
`default_nettype wire

// ===== tb/sv/hmac_sha256_stream_tb.sv =====
// testbench for hmac_sha256_stream: byte messages checked against a local hmac-sha-256 predictor
`timescale 1ns / 1ps
`default_nettype none
module hmac_sha256_stream_tb;

	localparam int HoldCycles = 400;
	localparam int StallLimit = 6000;
	localparam int RegStride = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        no_data = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [63:0] digest_word;
	logic        last_word;

	hmac_sha256_stream dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] StartHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// predictor state
	logic [63:0]      key_shadow [hss_pkg::KeyWords];
	logic [31:0]      hash_state [8];
	logic [7:0]       msg_block [64];
	logic [63:0]      byte_count;
	hss_pkg::result_t digest_q [$];

	int errors = 0;
	int items_sent = 0;
	bit no_idle = 1'b0;
	int stall_cycles = 0;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wt, t1, t2;
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int t = 0; t < 64; t++) begin
			if (t < 16) begin
				wt = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
			end else begin
				wt = w[(t-16)&15] + w[(t-7)&15]
					+ (ror32(w[(t-15)&15], 7) ^ ror32(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3))
					+ (ror32(w[(t-2)&15], 17) ^ ror32(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10));
			end
			w[t&15] = wt;
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + wt;
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endfunction

	function automatic void hash_padded_key(input logic [7:0] pad);
		for (int i = 0; i < 8; i++) hash_state[i] = StartHash[i];
		for (int i = 0; i < 64; i++)
			msg_block[i] = key_shadow[i/8][63 - 8*(i%8) -: 8] ^ pad;
		compress_block();
	endfunction

	function automatic void put_bit_length(input logic [63:0] bits);
		for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63 - 8*i -: 8];
	endfunction

	function automatic void predict_hmac(input logic [7:0] b, input logic fin, input logic nd);
		logic [31:0] inner [8];
		int idx;
		hss_pkg::result_t r;
		if (nd && !fin) return;
		if (byte_count == 0) begin
			hash_padded_key(hss_pkg::IpadByte);
			byte_count = 64;
		end
		if (!nd) begin
			msg_block[byte_count[5:0]] = b;
			byte_count++;
			if (byte_count[5:0] == 0) compress_block();
		end
		if (!fin) return;
		idx = byte_count[5:0];
		msg_block[idx] = 8'h80;
		idx++;
		if (idx > 56) begin
			while (idx < 64) begin msg_block[idx] = 8'h00; idx++; end
			compress_block();
			idx = 0;
		end
		while (idx < 56) begin msg_block[idx] = 8'h00; idx++; end
		put_bit_length(byte_count << 3);
		compress_block();
		for (int i = 0; i < 8; i++) inner[i] = hash_state[i];
		hash_padded_key(hss_pkg::OpadByte);
		for (int i = 0; i < 32; i++) msg_block[i] = inner[i/4][31 - 8*(i%4) -: 8];
		msg_block[32] = 8'h80;
		for (int i = 33; i < 56; i++) msg_block[i] = 8'h00;
		put_bit_length(64'd768);
		compress_block();
		for (int i = 0; i < 4; i++) begin
			r.digest_word = {hash_state[2*i], hash_state[2*i+1]};
			r.last_word = (i == 3);
			digest_q.push_back(r);
		end
		for (int i = 0; i < 8; i++) hash_state[i] = StartHash[i];
		byte_count = 0;
	endfunction

	// accept side: stall watchdog, predict on input words, check on output words
	always @(posedge clk) begin
		hss_pkg::result_t want;
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (psel && penable))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= StallLimit) begin
				$display("Regression FAIL");
				$finish;
			end
			if (push && !full) predict_hmac(data_byte, last_byte, no_data);
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest word %h", digest_word);
					errors++;
				end else begin
					want = digest_q.pop_front();
					if (digest_word !== want.digest_word) begin
						$error("digest_word expected %h actual %h", want.digest_word, digest_word);
						errors++;
					end
					if (last_word !== want.last_word) begin
						$error("last_word expected %b actual %b", want.last_word, last_word);
						errors++;
					end
				end
			end
		end
	end

	always @(negedge clk)
		pop = no_idle ? 1'b1 : ($urandom_range(0, 99) >= 25);

	task automatic send_word(input logic [7:0] b, input logic fin, input logic nd);
		if (!no_idle && $urandom_range(0, 99) < 25) begin
			push = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		push = 1'b1;
		data_byte = b;
		last_byte = fin;
		no_data = nd;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic drain();
		while (digest_q.size() != 0) @(negedge clk);
		repeat (HoldCycles) @(negedge clk);
	endtask

	task automatic write_key(input int idx, input logic [63:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 6'(idx * RegStride);
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		key_shadow[idx] = val;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_message(input int len);
		bit trail;
		trail = (len == 0) || ($urandom_range(0, 99) < 30);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 10) send_word(8'($urandom), 1'b0, 1'b1);
			send_word(8'($urandom), (i == len - 1) && !trail, 1'b0);
		end
		if (trail) send_word(8'($urandom), 1'b1, 1'b1);
	endtask

	function automatic int pick_length();
		case ($urandom_range(0, 9))
			7: return $urandom_range(55, 57);
			8: return $urandom_range(63, 65);
			default: return $urandom_range(0, 12);
		endcase
	endfunction

	// directed words: {data_byte, last_byte, no_data}
	hss_pkg::item_t directed [] = '{
		'{8'h00, 1'b1, 1'b1},
		'{8'h5a, 1'b0, 1'b1},
		'{8'h00, 1'b1, 1'b1},
		'{8'h00, 1'b1, 1'b0},
		'{8'hff, 1'b1, 1'b0},
		'{8'h00, 1'b0, 1'b1},
		'{8'h00, 1'b0, 1'b0},
		'{8'hff, 1'b0, 1'b0},
		'{8'h3c, 1'b0, 1'b1},
		'{8'ha5, 1'b1, 1'b0},
		'{8'h12, 1'b0, 1'b0},
		'{8'h34, 1'b0, 1'b0},
		'{8'hff, 1'b1, 1'b1},
		'{8'h80, 1'b0, 1'b0},
		'{8'h01, 1'b1, 1'b0}
	};

	initial begin
		for (int i = 0; i < hss_pkg::KeyWords; i++) key_shadow[i] = '0;
		for (int i = 0; i < 8; i++) hash_state[i] = StartHash[i];
		byte_count = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_word(directed[i].data_byte, directed[i].last_byte, directed[i].no_data);
		drain();

		// all-ones key, then random keys with no idling, then a sparse key
		for (int k = 0; k < hss_pkg::KeyWords; k++) write_key(k, '1);
		while (items_sent < 60) send_message(pick_length());
		drain();

		for (int k = 0; k < hss_pkg::KeyWords; k++) write_key(k, {$urandom, $urandom});
		no_idle = 1'b1;
		while (items_sent < 100) send_message(pick_length());
		drain();
		no_idle = 1'b0;

		for (int k = 0; k < hss_pkg::KeyWords; k++)
			write_key(k, (k < 2) ? {$urandom, $urandom} : 64'd0);
		while (items_sent < 140) send_message(pick_length());
		drain();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ===== hmac_sha256_stream.f =====
+incdir+rtl
rtl/hss_pkg.sv
rtl/hss_front.sv
rtl/hss_back.sv
rtl/hmac_sha256_stream.sv
rtl/hss_checker.sv
tb/sv/hmac_sha256_stream_tb.sv
